@@ hw/rtl/qmsmm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmsmm_pkg
// shared types, codes and tables for the quad mode select and motor mixer
// ----------------------------------------------------------------------------
package qmsmm_pkg;

	localparam int CountW = 15;
	localparam int CmdW   = 8;
	localparam int ThrW   = CountW + 2;   // idle count plus signed command
	localparam int MixW   = ThrW + 1;     // throttle plus two signed axes

	localparam int InDataW  = 72;
	localparam int OutDataW = 64;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_IDLE_THROTTLE = 2'd0,
		REG_MOTOR_MIN     = 2'd1,
		REG_MOTOR_MAX     = 2'd2
	} reg_idx_t;

	// pilot mode codes
	typedef enum logic [1:0] {
		MODE_MANUAL    = 2'd0,
		MODE_AUGMENTED = 2'd1,
		MODE_AUTOPILOT = 2'd2,
		MODE_IDLE      = 2'd3
	} pilot_mode_t;

	localparam logic [3:0] OVR_FAILSAFE = 4'd15;

	// axis bit positions in an override mask
	localparam int AX_T = 0;
	localparam int AX_R = 1;
	localparam int AX_P = 2;
	localparam int AX_Y = 3;

	// axes taken from the radio for each override code
	localparam logic [3:0] OVR_AXES [16] = '{
		4'b0000, 4'b0001, 4'b0010, 4'b0100,
		4'b1000, 4'b0011, 4'b0101, 4'b1001,
		4'b0110, 4'b1010, 4'b1100, 4'b0111,
		4'b1011, 4'b1101, 4'b1110, 4'b0000
	};

	// input word, last field in the lowest bits
	typedef struct packed {
		logic [CmdW-1:0] auto_yaw;
		logic [CmdW-1:0] auto_pitch;
		logic [CmdW-1:0] auto_roll;
		logic [CmdW-1:0] auto_throttle;
		logic [3:0]      override_mode;
		logic [CmdW-1:0] radio_yaw;
		logic [CmdW-1:0] radio_pitch;
		logic [CmdW-1:0] radio_roll;
		logic [CmdW-1:0] radio_throttle;
		logic [1:0]      pilot_mode;
	} in_item_t;

	// result word, last field in the lowest bits
	typedef struct packed {
		logic              fail_safe_flag;
		logic              motors_updated;
		logic [CountW-1:0] motor_four;
		logic [CountW-1:0] motor_three;
		logic [CountW-1:0] motor_two;
		logic [CountW-1:0] motor_one;
	} out_item_t;

	typedef struct packed {
		logic [CountW-1:0] idle_throttle;
		logic [CountW-1:0] motor_min;
		logic [CountW-1:0] motor_max;
	} cfg_t;

	// selected axis commands
	typedef struct packed {
		logic signed [ThrW-1:0] thr;
		logic signed [CmdW-1:0] rol;
		logic signed [CmdW-1:0] pit;
		logic signed [CmdW-1:0] yaw;
		logic                   fail_safe_set;
	} cmd_t;

	// max check first, then min
	function automatic logic [CountW-1:0] clamp_count(
		input logic signed [MixW-1:0] v,
		input logic [CountW-1:0]      lo,
		input logic [CountW-1:0]      hi
	);
		logic signed [MixW-1:0] lo_s;
		logic signed [MixW-1:0] hi_s;
		lo_s = $signed({{(MixW-CountW){1'b0}}, lo});
		hi_s = $signed({{(MixW-CountW){1'b0}}, hi});
		if (v > hi_s)
			return hi;
		else if (v < lo_s)
			return lo;
		else
			return v[CountW-1:0];
	endfunction

endpackage

@@ hw/rtl/qmsmm_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmsmm_cfg_regs
// configuration registers: idle throttle, motor minimum and maximum counts
// ----------------------------------------------------------------------------
module qmsmm_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [qmsmm_pkg::CountW-1:0] cfg_data,
	output qmsmm_pkg::cfg_t            cfg
);
	import qmsmm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_throttle <= '0;
			cfg_q.motor_min     <= '0;
			cfg_q.motor_max     <= '1;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IDLE_THROTTLE: cfg_q.idle_throttle <= cfg_data;
				REG_MOTOR_MIN:     cfg_q.motor_min     <= cfg_data;
				REG_MOTOR_MAX:     cfg_q.motor_max     <= cfg_data;
				default: ;  // unused index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/qmsmm_cmd_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmsmm_cmd_select
// picks radio, autopilot or idle commands per pilot mode and override mode
// ----------------------------------------------------------------------------
module qmsmm_cmd_select (
	input  qmsmm_pkg::in_item_t item,
	input  qmsmm_pkg::cfg_t     cfg,
	output qmsmm_pkg::cmd_t     cmd
);
	import qmsmm_pkg::*;

	logic [3:0]      axes;
	logic [CmdW-1:0] thr8;
	logic            use_idle;

	always_comb begin
		axes     = OVR_AXES[item.override_mode];
		use_idle = 1'b0;
		thr8     = item.radio_throttle;
		cmd.rol  = $signed(item.radio_roll);
		cmd.pit  = $signed(item.radio_pitch);
		cmd.yaw  = $signed(item.radio_yaw);
		cmd.fail_safe_set = 1'b0;
		unique case (pilot_mode_t'(item.pilot_mode))
			MODE_MANUAL: ;
			MODE_AUGMENTED, MODE_AUTOPILOT: begin
				thr8    = axes[AX_T] ? item.radio_throttle : item.auto_throttle;
				cmd.rol = $signed(axes[AX_R] ? item.radio_roll  : item.auto_roll);
				cmd.pit = $signed(axes[AX_P] ? item.radio_pitch : item.auto_pitch);
				cmd.yaw = $signed(axes[AX_Y] ? item.radio_yaw   : item.auto_yaw);
				cmd.fail_safe_set = (item.override_mode == OVR_FAILSAFE);
			end
			default: begin
				use_idle = 1'b1;
				cmd.rol  = '0;
				cmd.pit  = '0;
				cmd.yaw  = '0;
			end
		endcase
		cmd.thr = $signed({2'b00, cfg.idle_throttle});
		if (!use_idle)
			cmd.thr = cmd.thr + ThrW'($signed(thr8));
	end

endmodule

@@ hw/rtl/qmsmm_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmsmm_mixer
// x-form mix, clamp and held motor counts with the sticky fail-safe latch
// ----------------------------------------------------------------------------
module qmsmm_mixer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  qmsmm_pkg::cmd_t      cmd,
	input  qmsmm_pkg::cfg_t      cfg,
	output qmsmm_pkg::out_item_t result
);
	import qmsmm_pkg::*;

	logic [CountW-1:0] held_q [4];
	logic [CountW-1:0] held_d [4];
	logic              fail_safe_q;
	logic              fail_safe_d;
	logic              updated;

	logic signed [MixW-1:0] thr_m;
	logic signed [MixW-1:0] rol_m;
	logic signed [MixW-1:0] pit_m;
	logic signed [MixW-1:0] yaw_m;

	always_comb begin
		thr_m   = MixW'(cmd.thr);
		rol_m   = MixW'(cmd.rol);
		pit_m   = MixW'(cmd.pit);
		yaw_m   = MixW'(cmd.yaw);
		updated = (cmd.thr != '0);
		held_d  = held_q;
		if (updated) begin
			held_d[0] = clamp_count(thr_m + pit_m - yaw_m, cfg.motor_min, cfg.motor_max);
			held_d[1] = clamp_count(thr_m - rol_m + yaw_m, cfg.motor_min, cfg.motor_max);
			held_d[2] = clamp_count(thr_m - pit_m - yaw_m, cfg.motor_min, cfg.motor_max);
			held_d[3] = clamp_count(thr_m + rol_m + yaw_m, cfg.motor_min, cfg.motor_max);
		end
		fail_safe_d = fail_safe_q | cmd.fail_safe_set;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '{default: '0};
			fail_safe_q <= 1'b0;
		end else if (step) begin
			held_q      <= held_d;
			fail_safe_q <= fail_safe_d;
		end
	end

	assign result.motor_one      = held_d[0];
	assign result.motor_two      = held_d[1];
	assign result.motor_three    = held_d[2];
	assign result.motor_four     = held_d[3];
	assign result.motors_updated = updated;
	assign result.fail_safe_flag = fail_safe_d;

endmodule

@@ hw/rtl/quad_mode_select_and_motor_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_mode_select_and_motor_mixer
// pilot mode command select and x-form quad motor mixer with clamp and hold
// ----------------------------------------------------------------------------
//
//  channel   direction  width  handshake            content
//  s_*       in         72     tvalid/tready        pilot and autopilot commands
//  m_*       out        64     tvalid/tready        held motor counts and flags
//  cfg_*     in         15     cfg_we, no wait      idle, min and max counts
//
//  one word per cycle sustained while m_tready is high; m_tvalid rises once a
//  word passes the input register, mix and clamp, into the result register
//  held counts and fail-safe latch update as a word moves into the result
//  register, so state follows word order exactly
//  a stall on m_tready fills the input register, then drops s_tready
//  asynchronous reset clears valids, held counts and latch; config to reset
//  values (max count all ones)
//
module quad_mode_select_and_motor_mixer (
	input  logic                          clk,
	input  logic                          arst_n,
	// pilot_mode[1:0], radio_throttle[9:2], radio_roll[17:10],
	// radio_pitch[25:18], radio_yaw[33:26], override_mode[37:34],
	// auto_throttle[45:38], auto_roll[53:46], auto_pitch[61:54],
	// auto_yaw[69:62], zero [71:70]
	input  logic [qmsmm_pkg::InDataW-1:0] s_tdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// motor_one[14:0], motor_two[29:15], motor_three[44:30],
	// motor_four[59:45], motors_updated[60], fail_safe_flag[61], zero [63:62]
	output logic [qmsmm_pkg::OutDataW-1:0] m_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [qmsmm_pkg::CountW-1:0]  cfg_data
);
	import qmsmm_pkg::*;

	localparam int InBits  = $bits(in_item_t);
	localparam int OutBits = $bits(out_item_t);

	cfg_t      cfg;
	cmd_t      cmd;
	out_item_t result;

	// input register
	logic      valid_s1;
	in_item_t  item_s1;
	// result register
	logic      valid_s2;
	out_item_t item_s2;

	logic in_fire;
	logic load_s2;

	// result register frees when empty or taken this cycle
	assign load_s2  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || !valid_s2 || m_tready;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_item_t'(s_tdata[InBits-1:0]);
		end
	end

	qmsmm_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	qmsmm_cmd_select u_cmd_select (
		.item (item_s1),
		.cfg  (cfg),
		.cmd  (cmd)
	);

	// state steps exactly once per word entering the result register
	qmsmm_mixer u_mixer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (load_s2),
		.cmd    (cmd),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			item_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OutDataW-OutBits){1'b0}}, item_s2};

endmodule

@@ hw/rtl/qmsmm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmsmm_checker
// port-level checks for the quad mode select and motor mixer
// ----------------------------------------------------------------------------
module qmsmm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic [qmsmm_pkg::OutDataW-1:0] m_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready
);
	import qmsmm_pkg::*;

	localparam int MotorBits = 4 * CountW;
	localparam int UpdBit    = MotorBits;
	localparam int FsBit     = MotorBits + 1;

	logic                 out_fire;
	logic [MotorBits-1:0] last_motors_q;
	logic                 last_fs_q;

	assign out_fire = m_tvalid && m_tready;

	// last delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_motors_q <= '0;
			last_fs_q     <= 1'b0;
		end else if (out_fire) begin
			last_motors_q <= m_tdata[MotorBits-1:0];
			last_fs_q     <= m_tdata[FsBit];
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed under stall");

	// input side only blocks behind a stalled full result
	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// fail-safe flag stays set once delivered
	a_fs_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && last_fs_q |-> m_tdata[FsBit])
		else $error("fail-safe flag cleared");

	// word with no update repeats the previous motor counts
	a_hold_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !m_tdata[UpdBit] |-> m_tdata[MotorBits-1:0] == last_motors_q)
		else $error("motor counts changed without update");

endmodule

bind quad_mode_select_and_motor_mixer qmsmm_checker u_qmsmm_checker (.*);

@@ tb/sv/quad_mode_select_and_motor_mixer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_mode_select_and_motor_mixer_test
// self-checking bench for the mode select and x-form motor mixer: command
// words go in over the slave stream, every word is mixed by a local model
// of the mixer and its held counts, and each result word is compared field by
// field in order; limits are rewritten between phases while the block is idle
// ----------------------------------------------------------------------------
module quad_mode_select_and_motor_mixer_test;
	import qmsmm_pkg::*;

	// override codes as they appear on the command word
	typedef enum logic [3:0] {
		TAKE_NONE, TAKE_T, TAKE_R, TAKE_P, TAKE_Y, TAKE_TR, TAKE_TP, TAKE_TY,
		TAKE_RP, TAKE_RY, TAKE_PY, TAKE_TRP, TAKE_TRY, TAKE_TPY, TAKE_RPY,
		TAKE_FAILSAFE
	} ovr_code_t;

	// index past the last register, writes there must do nothing
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam int MAX_COUNT       = 32767;
	localparam int MIN_PULSE_COUNT = 1000;
	localparam int MAX_PULSE_COUNT = 2000;
	localparam int WATCHDOG_LIMIT  = 1000;

	// --------------------------------------------------------------------
	// mixer model and queue of expected result words
	// --------------------------------------------------------------------
	class mixer_scoreboard;
		int idle_count;
		int min_count;
		int max_count;
		logic [CountW-1:0] held_counts [4];
		bit fail_safe_seen;
		out_item_t expected_words [$];
		int errors;

		function new();
			idle_count = 0;
			min_count = 0;
			max_count = MAX_COUNT;
			foreach (held_counts[k])
				held_counts[k] = '0;
			fail_safe_seen = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [CountW-1:0] val);
			case (idx)
				REG_IDLE_THROTTLE: idle_count = val;
				REG_MOTOR_MIN:     min_count = val;
				REG_MOTOR_MAX:     max_count = val;
				default: ;
			endcase
		endfunction

		// bit 0 throttle, 1 roll, 2 pitch, 3 yaw taken from the radio
		function logic [3:0] radio_axes(ovr_code_t code);
			case (code)
				TAKE_T:   return 4'b0001;
				TAKE_R:   return 4'b0010;
				TAKE_P:   return 4'b0100;
				TAKE_Y:   return 4'b1000;
				TAKE_TR:  return 4'b0011;
				TAKE_TP:  return 4'b0101;
				TAKE_TY:  return 4'b1001;
				TAKE_RP:  return 4'b0110;
				TAKE_RY:  return 4'b1010;
				TAKE_PY:  return 4'b1100;
				TAKE_TRP: return 4'b0111;
				TAKE_TRY: return 4'b1011;
				TAKE_TPY: return 4'b1101;
				TAKE_RPY: return 4'b1110;
				default:  return 4'b0000;
			endcase
		endfunction

		// crossed limits: values above max give max, all others give min
		function logic [CountW-1:0] bound_count(int v);
			if (v > max_count)
				return max_count[CountW-1:0];
			else if (v < min_count)
				return min_count[CountW-1:0];
			else
				return v[CountW-1:0];
		endfunction

		function void note_command(in_item_t c);
			int thr;
			int rol;
			int pit;
			int yaw;
			logic [3:0] take;
			out_item_t e;
			case (pilot_mode_t'(c.pilot_mode))
				MODE_MANUAL: begin
					thr = idle_count + $signed(c.radio_throttle);
					rol = $signed(c.radio_roll);
					pit = $signed(c.radio_pitch);
					yaw = $signed(c.radio_yaw);
				end
				MODE_AUGMENTED, MODE_AUTOPILOT: begin
					take = radio_axes(ovr_code_t'(c.override_mode));
					thr = idle_count + (take[0] ? $signed(c.radio_throttle)
						: $signed(c.auto_throttle));
					rol = take[1] ? $signed(c.radio_roll) : $signed(c.auto_roll);
					pit = take[2] ? $signed(c.radio_pitch) : $signed(c.auto_pitch);
					yaw = take[3] ? $signed(c.radio_yaw) : $signed(c.auto_yaw);
					if (c.override_mode == TAKE_FAILSAFE)
						fail_safe_seen = 1'b1;
				end
				default: begin
					thr = idle_count;
					rol = 0;
					pit = 0;
					yaw = 0;
				end
			endcase
			e = '0;
			if (thr != 0) begin
				held_counts[0] = bound_count(thr + pit - yaw);
				held_counts[1] = bound_count(thr - rol + yaw);
				held_counts[2] = bound_count(thr - pit - yaw);
				held_counts[3] = bound_count(thr + rol + yaw);
				e.motors_updated = 1'b1;
			end
			e.motor_one = held_counts[0];
			e.motor_two = held_counts[1];
			e.motor_three = held_counts[2];
			e.motor_four = held_counts[3];
			e.fail_safe_flag = fail_safe_seen;
			expected_words.push_back(e);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$error("%s expected %0d actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_word(out_item_t w);
			out_item_t e;
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
				return;
			end
			e = expected_words.pop_front();
			compare_field("motor_one", e.motor_one, w.motor_one);
			compare_field("motor_two", e.motor_two, w.motor_two);
			compare_field("motor_three", e.motor_three, w.motor_three);
			compare_field("motor_four", e.motor_four, w.motor_four);
			compare_field("motors_updated", e.motors_updated, w.motors_updated);
			compare_field("fail_safe_flag", e.fail_safe_flag, w.fail_safe_flag);
		endfunction
	endclass

	// --------------------------------------------------------------------
	// block ports, inputs driven to known values from time zero
	// --------------------------------------------------------------------
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic [InDataW-1:0]   s_tdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [OutDataW-1:0]  m_tdata;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [1:0]           cfg_index = '0;
	logic [CountW-1:0]    cfg_data = '0;

	mixer_scoreboard sb;

	// idling controls, percent per word on the sender, per cycle on the receiver
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	quad_mode_select_and_motor_mixer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: ready except during random stall bursts of random length
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 11);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: both handshakes sampled at the edge, before any drive updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_command(in_item_t'(s_tdata[$bits(in_item_t)-1:0]));
			if (m_tvalid && m_tready)
				sb.check_word(out_item_t'(m_tdata[$bits(out_item_t)-1:0]));
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// --------------------------------------------------------------------
	// stimulus helpers
	// --------------------------------------------------------------------

	// axis command, extremes and zero show up often
	function automatic logic [CmdW-1:0] pick_cmd();
		case ($urandom_range(0, 15))
			0: return 8'h80;
			1: return 8'h7f;
			2: return 8'h00;
			3: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	// random command word; with a small idle count the throttle is often
	// aimed at the zero point so the hold path gets exercised
	function automatic in_item_t random_command();
		in_item_t c;
		logic [CmdW-1:0] zero_thr;
		c.pilot_mode = 2'($urandom_range(0, 3));
		c.radio_throttle = pick_cmd();
		c.radio_roll = pick_cmd();
		c.radio_pitch = pick_cmd();
		c.radio_yaw = pick_cmd();
		c.override_mode = 4'($urandom_range(0, 15));
		c.auto_throttle = pick_cmd();
		c.auto_roll = pick_cmd();
		c.auto_pitch = pick_cmd();
		c.auto_yaw = pick_cmd();
		if (sb.idle_count <= 128 && $urandom_range(0, 3) == 0) begin
			zero_thr = 8'(-sb.idle_count);
			c.radio_throttle = zero_thr;
			c.auto_throttle = zero_thr;
		end
		return c;
	endfunction

	function automatic in_item_t make_cmd(pilot_mode_t mode,
		logic [CmdW-1:0] rt, logic [CmdW-1:0] rr, logic [CmdW-1:0] rp,
		logic [CmdW-1:0] ry, ovr_code_t ovr, logic [CmdW-1:0] at,
		logic [CmdW-1:0] ar, logic [CmdW-1:0] ap, logic [CmdW-1:0] ay);
		in_item_t c;
		c.pilot_mode = mode;
		c.radio_throttle = rt;
		c.radio_roll = rr;
		c.radio_pitch = rp;
		c.radio_yaw = ry;
		c.override_mode = ovr;
		c.auto_throttle = at;
		c.auto_roll = ar;
		c.auto_pitch = ap;
		c.auto_yaw = ay;
		return c;
	endfunction

	// present one word and hold it until accepted, then maybe leave a gap;
	// tvalid stays high between back-to-back words
	task automatic send_command(in_item_t c);
		s_tdata <= {{(InDataW-$bits(in_item_t)){1'b0}}, c};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// wait for a clock edge first so the monitor has seen the last accepted word
	task automatic wait_drained();
		@(posedge clk);
		while (sb.expected_words.size() != 0)
			@(posedge clk);
	endtask

	// all three limits in a row plus a write to the unused index;
	// only called while nothing is in flight
	task automatic apply_limits(int idle, int lo, int hi);
		cfg_we <= 1'b1;
		cfg_index <= REG_IDLE_THROTTLE;
		cfg_data <= idle[CountW-1:0];
		@(posedge clk);
		sb.set_reg(REG_IDLE_THROTTLE, idle[CountW-1:0]);
		cfg_index <= REG_MOTOR_MIN;
		cfg_data <= lo[CountW-1:0];
		@(posedge clk);
		sb.set_reg(REG_MOTOR_MIN, lo[CountW-1:0]);
		cfg_index <= REG_MOTOR_MAX;
		cfg_data <= hi[CountW-1:0];
		@(posedge clk);
		sb.set_reg(REG_MOTOR_MAX, hi[CountW-1:0]);
		cfg_index <= REG_UNUSED;
		cfg_data <= CountW'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// directed words: extremes, every mode and override code, the fail-safe
	// latch staying clear outside augmented and autopilot, zero throttle hold
	task automatic run_directed();
		in_item_t c;
		gap_pct = 15;
		stall_pct = 15;
		// reset limits, zero throttle in manual keeps the cleared counts
		send_command(make_cmd(MODE_MANUAL, 8'h00, 8'h00, 8'h00, 8'h00, TAKE_NONE,
			8'h00, 8'h00, 8'h00, 8'h00));
		// fail-safe code in idle and manual modes must not set the latch
		send_command(make_cmd(MODE_IDLE, 8'h7f, 8'h80, 8'h7f, 8'h80, TAKE_FAILSAFE,
			8'h80, 8'h7f, 8'h80, 8'h7f));
		send_command(make_cmd(MODE_MANUAL, 8'h80, 8'h7f, 8'h80, 8'h7f, TAKE_FAILSAFE,
			8'h7f, 8'h80, 8'h7f, 8'h80));
		send_command(make_cmd(MODE_MANUAL, 8'h7f, 8'h80, 8'h7f, 8'h80, TAKE_NONE,
			8'h00, 8'h00, 8'h00, 8'h00));
		// autopilot with zero throttle holds the last counts
		send_command(make_cmd(MODE_AUTOPILOT, 8'h7f, 8'h7f, 8'h7f, 8'h7f, TAKE_NONE,
			8'h00, 8'h80, 8'h7f, 8'h80));
		s_tvalid <= 1'b0;
		wait_drained();

		// pulse-width style limits, every override code, fail-safe last
		apply_limits(MIN_PULSE_COUNT, MIN_PULSE_COUNT, MAX_PULSE_COUNT);
		for (int k = 0; k < 16; k++) begin
			c = random_command();
			c.pilot_mode = k[0] ? MODE_AUTOPILOT : MODE_AUGMENTED;
			c.override_mode = 4'(k);
			send_command(c);
		end
		c = random_command();
		c.pilot_mode = MODE_IDLE;
		send_command(c);
		s_tvalid <= 1'b0;
		wait_drained();

		// radio and overridden throttle cancelling the idle count exactly
		apply_limits(100, 0, MAX_COUNT);
		send_command(make_cmd(MODE_MANUAL, 8'h9c, 8'h11, 8'h22, 8'h33, TAKE_NONE,
			8'h05, 8'h06, 8'h07, 8'h08));
		send_command(make_cmd(MODE_AUGMENTED, 8'h9c, 8'h44, 8'h55, 8'h66, TAKE_T,
			8'h05, 8'h06, 8'h07, 8'h08));
		s_tvalid <= 1'b0;
		wait_drained();
	endtask

	// one random phase under fixed limits, with a full drain halfway through
	task automatic run_phase(int idle, int lo, int hi, int n, int gap, int stall);
		apply_limits(idle, lo, hi);
		gap_pct = gap;
		stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) begin
				s_tvalid <= 1'b0;
				wait_drained();
			end
			send_command(random_command());
		end
		s_tvalid <= 1'b0;
		wait_drained();
	endtask

	// --------------------------------------------------------------------
	// main sequence
	// --------------------------------------------------------------------
	initial begin
		int lo;
		int hi;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		run_phase(0, 0, MAX_COUNT, 150, 20, 20);
		run_phase(MIN_PULSE_COUNT, MIN_PULSE_COUNT, MAX_PULSE_COUNT, 150, 10, 40);
		run_phase(MAX_COUNT, 0, MAX_COUNT, 150, 30, 10);
		run_phase($urandom_range(0, 128), 0, $urandom_range(0, MAX_COUNT), 150, 5, 5);
		run_phase(0, 0, 0, 150, 25, 25);
		run_phase(MAX_COUNT, MAX_COUNT, MAX_COUNT, 150, 10, 10);
		// crossed limits, max for values above it, min for all others
		lo = $urandom_range(1, MAX_COUNT);
		hi = $urandom_range(0, lo - 1);
		run_phase($urandom_range(0, MAX_COUNT), lo, hi, 150, 15, 15);
		// last part runs flat out on both sides
		lo = $urandom_range(0, 16000);
		hi = $urandom_range(lo, MAX_COUNT);
		run_phase($urandom_range(0, 4000), lo, hi, 150, 0, 0);

		// tail: catch any stray result word after the last expected one
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.expected_words.size() == 0) begin
			$display("simulation ok");
		end else begin
			if (sb.expected_words.size() != 0)
				$error("%0d result words never arrived", sb.expected_words.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/qmsmm_pkg.sv
hw/rtl/qmsmm_cfg_regs.sv
hw/rtl/qmsmm_cmd_select.sv
hw/rtl/qmsmm_mixer.sv
hw/rtl/quad_mode_select_and_motor_mixer.sv
hw/rtl/qmsmm_checker.sv
tb/sv/quad_mode_select_and_motor_mixer_test.sv
